// ===== rtl/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
package lr_pkg;

  localparam int unsigned COLOR_BITS = 8;

  // Input word kind
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  typedef logic [COLOR_BITS-1:0] color_t;

endpackage

// ===== rtl/line_rasterizer_top.sv =====
// Line rasterizer top level: input register, one-pass walk step, result register.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------------
//   in      | in_valid / in_stall    | in_kind, in_start_x/y, in_end_x/y
//   out     | out_valid / out_stall  | out_pixel_x/y, out_pixel_color, out_plot, out_last
//   cfg     | cfg_valid / cfg_ready  | cfg_draw_color
//
// One word per clock while the output is not stalled; a word passes the input register,
// then the walk logic feeding the result register.
// The walk state updates in the same cycle as the result register loads.
// rst_n is synchronous, active low; it clears the walk state and draw color.
// A stalled output holds its word; the input register takes a word while it
// is empty or while its own word moves on to the result register.
module line_rasterizer_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  lr_pkg::kind_t         in_kind,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output lr_pkg::color_t        out_pixel_color,
  output logic                  out_plot,
  output logic                  out_last,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  lr_pkg::color_t        cfg_draw_color
);
  import lr_pkg::*;

  localparam int unsigned ACC_BITS = COORD_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ACC_BITS-1:0]   acc_t;

  // Configuration
  color_t draw_color_r;

  // Input register
  logic   s1_valid_r;
  kind_t  s1_kind_r;
  coord_t s1_start_x_r, s1_start_y_r, s1_end_x_r, s1_end_y_r;

  // Walk state
  coord_t cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  acc_t   acc_x_r, acc_y_r, acc_x_nxt, acc_y_nxt;
  coord_t span_x_r, span_y_r, span_x_nxt, span_y_nxt;
  coord_t major_r, major_nxt;
  coord_t iter_r, iter_nxt;
  logic   x_rising_r, y_rising_r, x_rising_nxt, y_rising_nxt;
  logic   active_r, active_nxt;

  // Result register
  logic   out_valid_r;
  coord_t out_x_r, out_y_r;
  color_t out_color_r;
  logic   out_plot_r, out_last_r;
  logic   plot_nxt, last_nxt;

  logic   advance;
  logic   in_take;

  // Load path
  coord_t ld_x1, ld_y1, ld_x2, ld_y2;
  logic   ld_swap;

  // Step path
  acc_t   sum_x, sum_y;
  logic   move_x, move_y;
  logic   step_last;

  assign cfg_ready = 1'b1;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_color_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      draw_color_r <= cfg_draw_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r    <= in_kind;
      s1_start_x_r <= in_start_x;
      s1_start_y_r <= in_start_y;
      s1_end_x_r   <= in_end_x;
      s1_end_y_r   <= in_end_y;
    end
  end

  // Order endpoints so the walk starts at the larger y
  assign ld_swap = s1_end_y_r > s1_start_y_r;
  assign ld_x1   = ld_swap ? s1_end_x_r   : s1_start_x_r;
  assign ld_y1   = ld_swap ? s1_end_y_r   : s1_start_y_r;
  assign ld_x2   = ld_swap ? s1_start_x_r : s1_end_x_r;
  assign ld_y2   = ld_swap ? s1_start_y_r : s1_end_y_r;

  assign sum_x     = acc_x_r + acc_t'(span_x_r);
  assign sum_y     = acc_y_r + acc_t'(span_y_r);
  assign move_x    = sum_x > acc_t'(major_r);
  assign move_y    = sum_y > acc_t'(major_r);
  assign step_last = iter_r >= major_r;

  function automatic coord_t move_axis(input coord_t c, input logic rising);
    coord_t r;
    if (rising) begin
      r = c + coord_t'(1);
    end else if (c == '0) begin
      r = '0;
    end else begin
      r = c - coord_t'(1);
    end
    return r;
  endfunction

  always_comb begin
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    acc_x_nxt    = acc_x_r;
    acc_y_nxt    = acc_y_r;
    span_x_nxt   = span_x_r;
    span_y_nxt   = span_y_r;
    major_nxt    = major_r;
    iter_nxt     = iter_r;
    x_rising_nxt = x_rising_r;
    y_rising_nxt = y_rising_r;
    active_nxt   = active_r;
    plot_nxt     = 1'b0;
    last_nxt     = 1'b0;

    unique case (s1_kind_r)
      KIND_LOAD: begin
        x_rising_nxt = ld_x2 > ld_x1;
        y_rising_nxt = ld_y2 > ld_y1;
        span_x_nxt   = x_rising_nxt ? ld_x2 - ld_x1 : ld_x1 - ld_x2;
        span_y_nxt   = y_rising_nxt ? ld_y2 - ld_y1 : ld_y1 - ld_y2;
        major_nxt    = (span_x_nxt > span_y_nxt) ? span_x_nxt : span_y_nxt;
        cur_x_nxt    = ld_x1;
        cur_y_nxt    = ld_y1;
        acc_x_nxt    = '0;
        acc_y_nxt    = '0;
        iter_nxt     = '0;
        active_nxt   = 1'b1;
        plot_nxt     = 1'b1;
      end
      KIND_STEP: begin
        if (active_r) begin
          acc_x_nxt = move_x ? sum_x - acc_t'(major_r) : sum_x;
          acc_y_nxt = move_y ? sum_y - acc_t'(major_r) : sum_y;
          if (move_x) begin
            cur_x_nxt = move_axis(cur_x_r, x_rising_r);
          end
          if (move_y) begin
            cur_y_nxt = move_axis(cur_y_r, y_rising_r);
          end
          plot_nxt = move_x || move_y;
          last_nxt = step_last;
          if (step_last) begin
            active_nxt = 1'b0;
          end else begin
            iter_nxt = iter_r + coord_t'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      acc_x_r    <= '0;
      acc_y_r    <= '0;
      span_x_r   <= '0;
      span_y_r   <= '0;
      major_r    <= '0;
      iter_r     <= '0;
      x_rising_r <= 1'b0;
      y_rising_r <= 1'b0;
      active_r   <= 1'b0;
    end else if (advance) begin
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      acc_x_r    <= acc_x_nxt;
      acc_y_r    <= acc_y_nxt;
      span_x_r   <= span_x_nxt;
      span_y_r   <= span_y_nxt;
      major_r    <= major_nxt;
      iter_r     <= iter_nxt;
      x_rising_r <= x_rising_nxt;
      y_rising_r <= y_rising_nxt;
      active_r   <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x_r     <= cur_x_nxt;
      out_y_r     <= cur_y_nxt;
      out_color_r <= draw_color_r;
      out_plot_r  <= plot_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_plot        = out_plot_r;
  assign out_last        = out_last_r;

  // A load word always yields a plotted, non-final pixel
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_kind_r == KIND_LOAD) |=> (out_valid && out_plot && !out_last))
    else $error("load result not plotted or flagged last");

  // The final iteration closes the segment
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last_nxt) |=> !active_r)
    else $error("segment still active after last iteration");

  // Iteration count never passes the major span
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (iter_r <= major_r))
    else $error("iteration count beyond major span");

  // Accumulators stay within the major span between steps
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (acc_x_r <= acc_t'(major_r) && acc_y_r <= acc_t'(major_r)))
    else $error("error accumulator out of range");

endmodule

// ===== tb/lr_pixel_checker.sv =====
`timescale 1ns / 100ps
// Pixel word scoreboard for the line rasterizer: tracks the walk, predicts and checks each word.
module lr_pixel_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  input  logic                  in_stall,
  input  lr_pkg::kind_t         in_kind,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,

  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COORD_BITS-1:0] out_pixel_x,
  input  logic [COORD_BITS-1:0] out_pixel_y,
  input  lr_pkg::color_t        out_pixel_color,
  input  logic                  out_plot,
  input  logic                  out_last,

  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  lr_pkg::color_t        cfg_draw_color,

  output int unsigned           err_count,
  output int unsigned           pending,
  output int unsigned           n_checked,
  output int unsigned           n_plot,
  output int unsigned           n_last
);
  import lr_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   acc_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   plot;
    logic   last;
  } pixel_t;

  color_t draw_color;
  coord_t cur_x, cur_y, span_x, span_y, major_span;
  acc_t   acc_x, acc_y, iter_cnt;
  logic   x_rising, y_rising, walking;
  pixel_t pixel_q[$];

  // Rising axes wrap at the coordinate width, falling axes stop at zero.
  function automatic coord_t next_coord(coord_t c, logic rising);
    if (rising) return c + 1'b1;
    return (c == '0) ? c : c - 1'b1;
  endfunction

  task automatic predict_pixel(kind_t kind, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    coord_t x1, y1, x2, y2;
    pixel_t p;
    logic   moved;
    logic   done;
    x1 = sx;
    y1 = sy;
    x2 = ex;
    y2 = ey;
    moved = 1'b0;
    done = 1'b0;
    if (kind == KIND_LOAD) begin
      // Walk always starts from the larger y.
      if (ey > sy) begin
        x1 = ex;
        y1 = ey;
        x2 = sx;
        y2 = sy;
      end
      x_rising = x2 > x1;
      y_rising = y2 > y1;
      span_x = x_rising ? x2 - x1 : x1 - x2;
      span_y = y_rising ? y2 - y1 : y1 - y2;
      major_span = (span_x > span_y) ? span_x : span_y;
      cur_x = x1;
      cur_y = y1;
      acc_x = '0;
      acc_y = '0;
      iter_cnt = '0;
      walking = 1'b1;
      moved = 1'b1;
    end else if (walking) begin
      acc_x = acc_x + span_x;
      acc_y = acc_y + span_y;
      if (acc_x > major_span) begin
        moved = 1'b1;
        acc_x = acc_x - major_span;
        cur_x = next_coord(cur_x, x_rising);
      end
      if (acc_y > major_span) begin
        moved = 1'b1;
        acc_y = acc_y - major_span;
        cur_y = next_coord(cur_y, y_rising);
      end
      done = (iter_cnt >= major_span);
      if (done) walking = 1'b0;
      else iter_cnt = iter_cnt + 1'b1;
    end
    p.x = cur_x;
    p.y = cur_y;
    p.color = draw_color;
    p.plot = moved;
    p.last = done;
    pixel_q.push_back(p);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pixel_q.size() == 0) begin
      $display("%0t: unexpected pixel word x=%0d y=%0d", $time, out_pixel_x, out_pixel_y);
      err_count++;
    end else begin
      want = pixel_q.pop_front();
      check_field("pixel_x", want.x, out_pixel_x);
      check_field("pixel_y", want.y, out_pixel_y);
      check_field("pixel_color", want.color, out_pixel_color);
      check_field("plot", want.plot, out_plot);
      check_field("last", want.last, out_last);
      n_checked++;
      if (out_plot === 1'b1) n_plot++;
      if (out_last === 1'b1) n_last++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      draw_color = '0;
      cur_x = '0;
      cur_y = '0;
      span_x = '0;
      span_y = '0;
      major_span = '0;
      acc_x = '0;
      acc_y = '0;
      iter_cnt = '0;
      x_rising = 1'b0;
      y_rising = 1'b0;
      walking = 1'b0;
      pixel_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) draw_color = cfg_draw_color;
      if (out_valid && !out_stall) check_pixel();
      if (in_valid && !in_stall)
        predict_pixel(in_kind, in_start_x, in_start_y, in_end_x, in_end_y);
      pending <= pixel_q.size();
    end
  end

endmodule

// ===== tb/tb_line_rasterizer_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the line rasterizer: clock, reset, stimulus, flow control and verdict.
module tb_line_rasterizer_top;
  import lr_pkg::*;

  localparam int unsigned COORD_BITS  = 12;
  localparam int          COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned PHASE_WORDS = 280;

  typedef logic [COORD_BITS-1:0] coord_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  kind_t  in_kind = KIND_LOAD;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   out_stall = 1'b0;
  logic   cfg_valid = 1'b0;
  color_t cfg_draw_color = '0;

  logic   in_stall, out_valid, out_plot, out_last, cfg_ready;
  coord_t out_pixel_x, out_pixel_y;
  color_t out_pixel_color;

  int unsigned err_count, pending, n_checked, n_plot, n_last;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_cnt = 0;
  int unsigned backpressure_cnt = 0;
  int unsigned hold_left = 0;
  logic        long_hold_go = 1'b0;
  logic        long_hold_done = 1'b0;

  always #5 clk = ~clk;

  line_rasterizer_top #(.COORD_BITS(COORD_BITS)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_plot        (out_plot),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_draw_color  (cfg_draw_color)
  );

  lr_pixel_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_plot        (out_plot),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_draw_color  (cfg_draw_color),
    .err_count       (err_count),
    .pending         (pending),
    .n_checked       (n_checked),
    .n_plot          (n_plot),
    .n_last          (n_last)
  );

  // Output side: random stall, plus one long hold-off on request.
  always @(posedge clk) begin
    if (long_hold_go && !long_hold_done) begin
      hold_left = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (in_valid && in_stall) backpressure_cnt <= backpressure_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(kind_t kind, int sx, int sy, int ex, int ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_start_x <= sx[COORD_BITS-1:0];
    in_start_y <= sy[COORD_BITS-1:0];
    in_end_x <= ex[COORD_BITS-1:0];
    in_end_y <= ey[COORD_BITS-1:0];
    // Hold the word until it is taken.
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Step words carry random coordinates, which the block ignores.
  task automatic send_steps(int n);
    repeat (n) send_word(KIND_STEP, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                         $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
  endtask

  task automatic write_color(color_t c);
    cfg_valid <= 1'b1;
    cfg_draw_color <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int pick_start();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 16) return COORD_MAX;
    return $urandom_range(COORD_MAX);
  endfunction

  // One segment: load, then usually a full walk; sometimes cut short or overrun.
  task automatic run_segment(output int unsigned n_words);
    int sx, sy, ex, ey, reach, dx, dy, major, steps, r;
    sx = pick_start();
    sy = pick_start();
    r = $urandom_range(99);
    reach = (r < 75) ? 12 : (r < 93) ? 60 : COORD_MAX;
    ex = clamp_coord(sx + int'($urandom_range(2 * reach)) - reach);
    ey = clamp_coord(sy + int'($urandom_range(2 * reach)) - reach);
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    major = (dx > dy) ? dx : dy;
    steps = major + 1;
    r = $urandom_range(99);
    if (reach == COORD_MAX || r < 10) steps = $urandom_range((steps < 20) ? steps : 20, 0);
    else if (r < 25) steps = steps + $urandom_range(2, 1);
    send_word(KIND_LOAD, sx, sy, ex, ey);
    send_steps(steps);
    n_words = steps + 1;
  endtask

  task automatic run_phase(int unsigned n_target);
    int unsigned n_done, n_seg, r;
    n_done = 0;
    while (n_done < n_target) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_steps(1);
        n_done++;
      end else if (r < 12) begin
        send_word(KIND_LOAD, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
        n_done++;
      end else begin
        run_segment(n_seg);
        n_done += n_seg;
      end
    end
  endtask

  initial begin
    color_t mid_color;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_color(8'hFF);
    // Step before any load, then a single-pixel segment.
    send_steps(1);
    send_word(KIND_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_steps(2);
    send_word(KIND_LOAD, 0, 0, 3, 0);
    send_steps(4);
    // End y above start y: endpoints swap.
    send_word(KIND_LOAD, 3, 0, 0, 2);
    send_steps(4);
    // Full-range diagonal, abandoned by a new load.
    send_word(KIND_LOAD, 0, COORD_MAX, COORD_MAX, 0);
    send_steps(3);
    send_word(KIND_LOAD, 0, 0, 0, 1);
    send_steps(2);
    send_word(KIND_LOAD, COORD_MAX, 0, 0, COORD_MAX);
    send_steps(1);
    drain();

    write_color(8'h00);
    send_idle_pct = 19;
    recv_stall_pct <= 88;
    run_phase(PHASE_WORDS);
    drain();

    mid_color = color_t'($urandom_range(254, 1));
    write_color(mid_color);
    send_idle_pct = 88;
    recv_stall_pct <= 19;
    run_phase(PHASE_WORDS);
    drain();

    write_color(~mid_color);
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    long_hold_go <= 1'b1;
    run_phase(PHASE_WORDS);
    drain();

    repeat (8) @(posedge clk);
    $display("Summary: %0d words in, %0d pixel words checked, %0d plotted, %0d segment ends",
             words_sent, n_checked, n_plot, n_last);
    $display("Summary: 4 color settings, %0d cycles of input back-pressure, %0d mismatches",
             backpressure_cnt, err_count);
    if (err_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
